[sv/aspe_pkg.sv]
// ----------------------------------------------------------------------------
// aspe_pkg
// Shared helpers for the swap gain evaluator and its checker.
// ----------------------------------------------------------------------------
package aspe_pkg;

  localparam int unsigned BYTE_SHIFT = 3;

  // Rounds a bit width up to a whole number of bytes.
  function automatic int unsigned pad_bytes(input int unsigned w);
    int unsigned r;
    r = ((w + 7) >> BYTE_SHIFT) << BYTE_SHIFT;
    return r;
  endfunction

endpackage

[sv/amm_swap_profit_evaluator_top.sv]
// ----------------------------------------------------------------------------
// amm_swap_profit_evaluator_top
// Expected gain of one constant-product swap route per transaction.
// ----------------------------------------------------------------------------
// The block takes one route per clock and delivers one result per clock, in
// order, whenever the output is not stalled. The restoring divider, which
// resolves one quotient bit per pipeline stage, makes up most of the
// pipeline; the two multiplies ahead of it are split into half-width partial
// products over two stages each. A stall on the output freezes the whole
// pipeline, so s_tready follows the output side. The priority fee is sampled
// as each route is accepted; cfg_ready is always high.
module amm_swap_profit_evaluator_top #(
  parameter int AMOUNT_BITS   = 48,
  parameter int FEE_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // input_amount, pool_in_reserve, pool_out_reserve, fee_fraction, zero pad
  input  logic [aspe_pkg::pad_bytes(3*AMOUNT_BITS+FEE_FRAC_BITS)-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // expected_gain (two's complement), zero pad
  output logic [aspe_pkg::pad_bytes(AMOUNT_BITS+2)-1:0] m_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [AMOUNT_BITS-1:0]   cfg_data
);

  localparam int A     = AMOUNT_BITS;
  localparam int F     = FEE_FRAC_BITS;
  localparam int H     = (A + 1) / 2;
  localparam int L     = A - H;
  localparam int PW    = 2 * A;
  localparam int NW    = A + F + 1;
  localparam int G     = A + 2;
  localparam int OUT_W = aspe_pkg::pad_bytes(A + 2);

  logic          adv;
  logic [A-1:0]  prio_fee;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prio_fee <= '0;
    end else if (cfg_valid) begin
      prio_fee <= cfg_data;
    end
  end

  // Input fields.
  logic [A-1:0] in_amount, in_res_in, in_res_out;
  logic [F-1:0] in_fee;
  logic [F:0]   keep;

  assign in_amount  = s_tdata[A-1:0];
  assign in_res_in  = s_tdata[2*A-1:A];
  assign in_res_out = s_tdata[3*A-1:2*A];
  assign in_fee     = s_tdata[3*A+F-1:3*A];
  assign keep       = {1'b1, F'(0)} - {1'b0, in_fee};

  // Valid bits of the pipeline.
  logic v1, v2, v3, v4;
  logic dv [0:A];

  // Stage 1: partial products of amount * (1 - fee).
  logic [H+F:0] a1_lo;
  logic [L+F:0] a1_hi;
  logic [A:0]   cost1;
  logic [A-1:0] res_in1, res_out1;

  // Stage 2: net input.
  logic [A-1:0] net2, res_in2, res_out2;
  logic [A:0]   cost2;
  logic [NW-1:0] full2;

  // Stage 3: divisor and partial products of res_out * net.
  logic [A:0]     den3, den_sum;
  logic [A:0]     cost3;
  logic [2*H-1:0] p00;
  logic [H+L-1:0] p01, p10;
  logic [2*L-1:0] p11;

  // Stage 4: middle terms folded.
  logic [2*H-1:0] p00_4;
  logic [A:0]     cross4;
  logic [2*L-1:0] p11_4;
  logic [A:0]     den4, cost4;
  logic [PW-1:0]  prod;

  // Divider stages: index 0 is loaded with the full product.
  logic [A:0]   drem  [0:A];
  logic [A-1:0] dlow  [0:A];
  logic [A-1:0] dq    [0:A];
  logic [A:0]   dden  [0:A];
  logic [A:0]   dcost [0:A];
  logic [A:0]   nrem  [0:A-1];
  logic         nbit  [0:A-1];

  logic [G-1:0] gain;

  assign full2   = NW'(a1_lo) + (NW'(a1_hi) << H);
  assign den_sum = (A+1)'(res_in2) + (A+1)'(net2);
  assign prod    = PW'(p00_4) + (PW'(cross4) << H) + (PW'(p11_4) << (2 * H));
  assign gain    = G'(dq[A]) - G'(dcost[A]);

  // One restoring subtract per stage; the remainder always stays below the
  // divisor, so the quotient fits in AMOUNT_BITS.
  always_comb begin
    logic [A+1:0] t;
    t = '0;
    for (int i = 0; i < A; i++) begin
      t = {drem[i], dlow[i][A-1]};
      nbit[i] = (t >= G'(dden[i]));
      nrem[i] = nbit[i] ? (A+1)'(t - G'(dden[i])) : t[A:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i <= A; i++) begin
        dv[i] <= 1'b0;
      end
    end else if (adv) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      dv[0]    <= v4;
      for (int i = 0; i < A; i++) begin
        dv[i+1] <= dv[i];
      end
      m_tvalid <= dv[A];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_lo    <= (H+F+1)'(in_amount[H-1:0]) * (H+F+1)'(keep);
      a1_hi    <= (L+F+1)'(in_amount[A-1:H]) * (L+F+1)'(keep);
      cost1    <= (A+1)'(in_amount) + (A+1)'(prio_fee);
      res_in1  <= in_res_in;
      res_out1 <= in_res_out;

      net2     <= full2[A+F-1:F];
      cost2    <= cost1;
      res_in2  <= res_in1;
      res_out2 <= res_out1;

      den3  <= (den_sum == '0) ? (A+1)'(1) : den_sum;
      cost3 <= cost2;
      p00   <= (2*H)'(res_out2[H-1:0]) * (2*H)'(net2[H-1:0]);
      p01   <= (H+L)'(res_out2[H-1:0]) * (H+L)'(net2[A-1:H]);
      p10   <= (H+L)'(res_out2[A-1:H]) * (H+L)'(net2[H-1:0]);
      p11   <= (2*L)'(res_out2[A-1:H]) * (2*L)'(net2[A-1:H]);

      p00_4  <= p00;
      cross4 <= (A+1)'(p01) + (A+1)'(p10);
      p11_4  <= p11;
      den4   <= den3;
      cost4  <= cost3;

      drem[0]  <= (A+1)'(prod[PW-1:A]);
      dlow[0]  <= prod[A-1:0];
      dq[0]    <= '0;
      dden[0]  <= den4;
      dcost[0] <= cost4;
      for (int i = 0; i < A; i++) begin
        drem[i+1]  <= nrem[i];
        dlow[i+1]  <= dlow[i] << 1;
        dq[i+1]    <= {dq[i][A-2:0], nbit[i]};
        dden[i+1]  <= dden[i];
        dcost[i+1] <= dcost[i];
      end

      m_tdata <= OUT_W'(gain);
    end
  end

endmodule

[sv/aspe_checker.sv]
// ----------------------------------------------------------------------------
// aspe_checker
// Port-level checks for the swap gain evaluator, bound to its top level.
// ----------------------------------------------------------------------------
module aspe_checker #(
  parameter int AMOUNT_BITS   = 48
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [aspe_pkg::pad_bytes(AMOUNT_BITS+2)-1:0] m_tdata
);

  // The input side moves exactly when the output register can take a step.
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not track the output stall");

  // Bits above the gain field are padding and stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata >> (AMOUNT_BITS + 2)) == '0))
    else $error("m_tdata padding is not zero");

  a_stall_holds_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_valid_drops_after_transaction: assert property (@(posedge clk) disable iff (rst)
    (!rst && $fell(m_tvalid)) |-> $past(m_tready))
    else $error("m_tvalid dropped without a transaction");

endmodule

bind amm_swap_profit_evaluator_top aspe_checker #(
  .AMOUNT_BITS  (AMOUNT_BITS)
) u_aspe_checker (.*);
